### design/swq_pkg.sv
package swq_pkg;

  localparam int MAX_PROCS = 32;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int KEY_W     = 32;
  localparam int PID_W     = 5;
  localparam int PID_SPACE = 1 << PID_W;

  localparam logic FUNC_BLOCK   = 1'b0;
  localparam logic FUNC_UNBLOCK = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_FIND,
    S_QREAD,
    S_NREAD
  } state_t;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] sem_key;
    logic [PID_W-1:0] proc_id;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] released_proc;
  } rsp_t;

  // descriptor table update
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } cam_wr_t;

  // lookup outcome
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } cam_res_t;

endpackage

### design/swq_cam.sv
module swq_cam (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [swq_pkg::KEY_W-1:0] key,
  input  swq_pkg::cam_wr_t        wr,
  output swq_pkg::cam_res_t       res
);
  import swq_pkg::*;

  logic [KEY_W-1:0]     desc_key [MAX_PROCS];
  logic [MAX_PROCS-1:0] desc_active;
  logic [MAX_PROCS-1:0] hit_vec;
  logic [MAX_PROCS-1:0] free_vec;
  logic [MAX_PROCS-1:0] free_low;
  logic [MAX_PROCS-1:0] eq_vec;

  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      eq_vec[i] = (desc_key[i] == key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_active <= '0;
    end else if (wr.set) begin
      desc_active[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      desc_active[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      desc_key[wr.idx] <= wr.key;
    end
  end

  // registered compare and free vectors
  always_ff @(posedge clk) begin
    hit_vec  <= desc_active & eq_vec;
    free_vec <= ~desc_active;
  end

  // isolate lowest free entry
  assign free_low = free_vec & (~free_vec + 1'b1);

  // both vectors are one-hot or empty here, so an or-encode suffices
  always_comb begin
    res.hit      = |hit_vec;
    res.free_ok  = |free_vec;
    res.hit_idx  = '0;
    res.free_idx = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if (hit_vec[i]) res.hit_idx = res.hit_idx | IDX_W'(i);
      if (free_low[i]) res.free_idx = res.free_idx | IDX_W'(i);
    end
  end

endmodule

### design/semaphore_wait_queue_table_unit.sv
// channel  | handshake        | payload          | notes
// ---------+------------------+------------------+---------------------------------
// command  | start / busy     | req  (req_t)     | taken when start high, busy low
// result   | done (strobe)    | rsp  (rsp_t)     | valid for the single done cycle
//
// one transaction at a time: a block passes the match, find and queue read
// steps before done, an unblock the same, with a link read step added when
// the queue stays non-empty and the next_waiter link must be fetched; the
// steps follow the registered key compare, the synchronous queue ram read
// behind it and, for the longer unblock, the dependent link ram read
// rst is synchronous and active high; it clears the descriptor active bits
// and the control state; the queue rams are not cleared
// the receiver cannot stall: each result appears for one cycle with done,
// and a new command may be accepted in that same cycle
module semaphore_wait_queue_table_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  swq_pkg::req_t req,
  output logic          done,
  output swq_pkg::rsp_t rsp
);
  import swq_pkg::*;

  state_t state, state_next;
  req_t   req_q;
  cam_res_t res_q;
  cam_res_t cam_res;
  cam_wr_t  cam_wr;

  // queue ram: per descriptor {head, tail}
  logic [2*PID_W-1:0] qram [MAX_PROCS];
  logic [2*PID_W-1:0] q_rdata;
  logic               q_rd_en;
  logic [IDX_W-1:0]   q_raddr;
  logic               q_we;
  logic [IDX_W-1:0]   q_waddr;
  logic [2*PID_W-1:0] q_wdata;

  // link ram: per process id, the waiter queued behind it
  logic [PID_W-1:0] nram [PID_SPACE];
  logic [PID_W-1:0] n_rdata;
  logic             n_rd_en;
  logic [PID_W-1:0] n_raddr;
  logic             n_we;
  logic [PID_W-1:0] n_waddr;
  logic [PID_W-1:0] n_wdata;

  logic [PID_W-1:0] head;
  logic [PID_W-1:0] tail;
  logic             done_next;
  rsp_t             rsp_next;
  logic             accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign head   = q_rdata[2*PID_W-1:PID_W];
  assign tail   = q_rdata[PID_W-1:0];

  // key table with registered compare against the held command key
  swq_cam u_cam (
    .clk (clk),
    .rst (rst),
    .key (req_q.sem_key),
    .wr  (cam_wr),
    .res (cam_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
    if (state == S_FIND) res_q <= cam_res;
    rsp <= rsp_next;
  end

  // synchronous rams with registered read data
  always_ff @(posedge clk) begin
    if (q_we) qram[q_waddr] <= q_wdata;
    if (q_rd_en) q_rdata <= qram[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) nram[n_waddr] <= n_wdata;
    if (n_rd_en) n_rdata <= nram[n_raddr];
  end

  always_comb begin
    state_next = state;
    q_rd_en    = 1'b0;
    q_raddr    = cam_res.hit_idx;
    q_we       = 1'b0;
    q_waddr    = res_q.hit_idx;
    q_wdata    = {head, req_q.proc_id};
    n_rd_en    = 1'b0;
    n_raddr    = head;
    n_we       = 1'b0;
    n_waddr    = tail;
    n_wdata    = req_q.proc_id;
    cam_wr     = '{set: 1'b0, clr: 1'b0, idx: res_q.hit_idx, key: req_q.sem_key};
    done_next  = 1'b0;
    rsp_next   = '{status: ST_OK, released_proc: '0};

    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_MATCH;
      end
      // compare vectors are being registered
      S_MATCH: begin
        state_next = S_FIND;
      end
      // encoded hit drives the queue ram address
      S_FIND: begin
        q_rd_en    = 1'b1;
        state_next = S_QREAD;
      end
      S_QREAD: begin
        if (req_q.func == FUNC_BLOCK) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (res_q.hit) begin
            // link behind the current tail and move the tail
            n_we = 1'b1;
            q_we = 1'b1;
          end else if (res_q.free_ok) begin
            // claim the lowest free descriptor with a one-entry queue
            cam_wr.set = 1'b1;
            cam_wr.idx = res_q.free_idx;
            q_we       = 1'b1;
            q_waddr    = res_q.free_idx;
            q_wdata    = {req_q.proc_id, req_q.proc_id};
          end else begin
            rsp_next.status = ST_NO_FREE;
          end
        end else begin
          if (!res_q.hit) begin
            done_next       = 1'b1;
            state_next      = S_IDLE;
            rsp_next.status = ST_NOT_FOUND;
          end else if (head == tail) begin
            // last waiter leaves, descriptor returns to the free pool
            cam_wr.clr             = 1'b1;
            done_next              = 1'b1;
            state_next             = S_IDLE;
            rsp_next.released_proc = head;
          end else begin
            n_rd_en    = 1'b1;
            state_next = S_NREAD;
          end
        end
      end
      // q_rdata still holds the entry read in the find step
      S_NREAD: begin
        q_we                   = 1'b1;
        q_wdata                = {n_rdata, tail};
        done_next              = 1'b1;
        state_next             = S_IDLE;
        rsp_next.released_proc = head;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a result only ever appears once the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // failed requests never hand out a process
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status != ST_OK) |-> (rsp.released_proc == '0))
    else $error("released process on failed request");

  // table-full only ever answers a block
  a_status_func: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == ST_NO_FREE) |-> (req_q.func == FUNC_BLOCK))
    else $error("no-free status on unblock");

  // the link fetch follows the queue read directly
  a_nread_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_NREAD) |-> ($past(state) == S_QREAD))
    else $error("link read out of sequence");

endmodule
